@@ hw/rtl/poc_pkg.sv @@
// ----------------------------------------------------------------------------
// poc_pkg
// Shared types and constants of the pixel offset, clip and wrap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package poc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int DIM_BITS       = 15;
  localparam int COLOUR_BITS    = 24;
  localparam int TDATA_BITS     = 2 * FIELD_BITS + COLOUR_BITS;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET_X      = 3'd0,
    CFG_OFFSET_Y      = 3'd1,
    CFG_CANVAS_WIDTH  = 3'd2,
    CFG_CANVAS_HEIGHT = 3'd3,
    CFG_EDGE_MODE     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    EDGE_CLIP = 1'b0,
    EDGE_WRAP = 1'b1
  } edge_mode_e;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] offset_x;
    logic signed [FIELD_BITS-1:0] offset_y;
    logic [DIM_BITS-1:0]          canvas_width;
    logic [DIM_BITS-1:0]          canvas_height;
    edge_mode_e                   edge_mode;
  } cfg_t;

endpackage

@@ hw/rtl/poc_front.sv @@
// ----------------------------------------------------------------------------
// poc_front
// Input stage: adds the offset with wrap, applies the clip test and splits
// each coordinate into sign and magnitude for the remainder cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poc_front #(
  parameter int COORD_BITS = poc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  poc_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic [poc_pkg::FIELD_BITS-1:0]   pixel_x_i,
  input  logic [poc_pkg::FIELD_BITS-1:0]   pixel_y_i,
  input  logic [poc_pkg::COLOUR_BITS-1:0]  pixel_colour_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic                             x_neg_o,
  output logic [COORD_BITS-1:0]            x_mag_o,
  output logic                             y_neg_o,
  output logic [COORD_BITS-1:0]            y_mag_o,
  output logic [poc_pkg::COLOUR_BITS-1:0]  colour_o
);
  import poc_pkg::*;

  localparam int SUM_BITS  = FIELD_BITS + 1;
  localparam int EXT_BITS  = (COORD_BITS > SUM_BITS) ? COORD_BITS : SUM_BITS;
  localparam int DIFF_BITS = 34;

  logic signed [SUM_BITS-1:0]  sum_x, sum_y;
  logic signed [EXT_BITS-1:0]  ext_x, ext_y;
  logic                        v_q, v_d;
  logic [COORD_BITS-1:0]       x_q, y_q;
  logic [COLOUR_BITS-1:0]      colour_q;
  logic signed [DIFF_BITS-1:0] diff_x, diff_y, lim_x, lim_y;
  logic                        canvas_on, drop_x, drop_y, keep, advance;

  assign sum_x = {pixel_x_i[FIELD_BITS-1], pixel_x_i} +
                 {cfg_i.offset_x[FIELD_BITS-1], cfg_i.offset_x};
  assign sum_y = {pixel_y_i[FIELD_BITS-1], pixel_y_i} +
                 {cfg_i.offset_y[FIELD_BITS-1], cfg_i.offset_y};
  assign ext_x = EXT_BITS'(sum_x);
  assign ext_y = EXT_BITS'(sum_y);

  // The clip test uses the moved coordinate minus the offset at full width.
  assign diff_x = DIFF_BITS'(signed'(x_q)) - DIFF_BITS'(cfg_i.offset_x);
  assign diff_y = DIFF_BITS'(signed'(y_q)) - DIFF_BITS'(cfg_i.offset_y);
  assign lim_x  = signed'({{(DIFF_BITS-DIM_BITS){1'b0}}, cfg_i.canvas_width});
  assign lim_y  = signed'({{(DIFF_BITS-DIM_BITS){1'b0}}, cfg_i.canvas_height});
  assign drop_x = x_q[COORD_BITS-1] || (diff_x >= lim_x);
  assign drop_y = y_q[COORD_BITS-1] || (diff_y >= lim_y);

  assign canvas_on = (cfg_i.canvas_width != '0) || (cfg_i.canvas_height != '0);
  assign keep      = !(canvas_on && (cfg_i.edge_mode == EDGE_CLIP) && (drop_x || drop_y));

  // A dropped pixel leaves the stage without waiting for the cells.
  assign advance = !v_q || !keep || ready_i;
  assign ready_o = advance;
  assign valid_o = v_q && keep;
  assign v_d     = advance ? valid_i : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      x_q      <= ext_x[COORD_BITS-1:0];
      y_q      <= ext_y[COORD_BITS-1:0];
      colour_q <= pixel_colour_i;
    end
  end

  assign x_neg_o  = x_q[COORD_BITS-1];
  assign y_neg_o  = y_q[COORD_BITS-1];
  assign x_mag_o  = x_q[COORD_BITS-1] ? (~x_q + 1'b1) : x_q;
  assign y_mag_o  = y_q[COORD_BITS-1] ? (~y_q + 1'b1) : y_q;
  assign colour_o = colour_q;

endmodule

@@ hw/rtl/poc_cell.sv @@
// ----------------------------------------------------------------------------
// poc_cell
// One restoring remainder step for both axes: brings in one magnitude bit
// and subtracts the dimension where the partial remainder reaches it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poc_cell #(
  parameter int COORD_BITS = poc_pkg::COORD_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [poc_pkg::DIM_BITS-1:0]     width_i,
  input  logic [poc_pkg::DIM_BITS-1:0]     height_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic                             x_neg_i,
  input  logic [COORD_BITS-1:0]            x_mag_i,
  input  logic [poc_pkg::DIM_BITS-1:0]     x_rem_i,
  input  logic                             y_neg_i,
  input  logic [COORD_BITS-1:0]            y_mag_i,
  input  logic [poc_pkg::DIM_BITS-1:0]     y_rem_i,
  input  logic [poc_pkg::COLOUR_BITS-1:0]  colour_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic                             x_neg_o,
  output logic [COORD_BITS-1:0]            x_mag_o,
  output logic [poc_pkg::DIM_BITS-1:0]     x_rem_o,
  output logic                             y_neg_o,
  output logic [COORD_BITS-1:0]            y_mag_o,
  output logic [poc_pkg::DIM_BITS-1:0]     y_rem_o,
  output logic [poc_pkg::COLOUR_BITS-1:0]  colour_o
);
  import poc_pkg::*;

  logic [DIM_BITS:0]      x_try, y_try, x_div, y_div;
  logic [DIM_BITS-1:0]    x_rem_d, y_rem_d, x_rem_q, y_rem_q;
  logic                   v_q, v_d, x_neg_q, y_neg_q;
  logic [COORD_BITS-1:0]  x_mag_q, y_mag_q;
  logic [COLOUR_BITS-1:0] colour_q;

  assign x_try = {x_rem_i, x_mag_i[BIT]};
  assign y_try = {y_rem_i, y_mag_i[BIT]};
  assign x_div = {1'b0, width_i};
  assign y_div = {1'b0, height_i};

  // With a non-zero dimension the partial remainder stays below it, so the
  // difference always fits the remainder width.
  assign x_rem_d = (x_try >= x_div) ? DIM_BITS'(x_try - x_div) : x_try[DIM_BITS-1:0];
  assign y_rem_d = (y_try >= y_div) ? DIM_BITS'(y_try - y_div) : y_try[DIM_BITS-1:0];

  assign ready_o = !v_q || ready_i;
  assign v_d     = ready_o ? valid_i : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_neg_q  <= x_neg_i;
      x_mag_q  <= x_mag_i;
      x_rem_q  <= x_rem_d;
      y_neg_q  <= y_neg_i;
      y_mag_q  <= y_mag_i;
      y_rem_q  <= y_rem_d;
      colour_q <= colour_i;
    end
  end

  assign valid_o  = v_q;
  assign x_neg_o  = x_neg_q;
  assign x_mag_o  = x_mag_q;
  assign x_rem_o  = x_rem_q;
  assign y_neg_o  = y_neg_q;
  assign y_mag_o  = y_mag_q;
  assign y_rem_o  = y_rem_q;
  assign colour_o = colour_q;

endmodule

@@ hw/rtl/poc_back.sv @@
// ----------------------------------------------------------------------------
// poc_back
// Output stage: turns the remainder into a floored modulo, picks the wrapped
// or the moved coordinate and holds the result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poc_back #(
  parameter int COORD_BITS = poc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  poc_pkg::cfg_t                    cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic                             x_neg_i,
  input  logic [COORD_BITS-1:0]            x_mag_i,
  input  logic [poc_pkg::DIM_BITS-1:0]     x_rem_i,
  input  logic                             y_neg_i,
  input  logic [COORD_BITS-1:0]            y_mag_i,
  input  logic [poc_pkg::DIM_BITS-1:0]     y_rem_i,
  input  logic [poc_pkg::COLOUR_BITS-1:0]  colour_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [poc_pkg::FIELD_BITS-1:0]   mapped_x_o,
  output logic [poc_pkg::FIELD_BITS-1:0]   mapped_y_o,
  output logic [poc_pkg::COLOUR_BITS-1:0]  mapped_colour_o
);
  import poc_pkg::*;

  localparam int OUT_EXT = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

  logic                       canvas_on, wrap_on;
  logic [DIM_BITS-1:0]        x_fix, y_fix;
  logic [COORD_BITS-1:0]      x_orig, y_orig, x_sel, y_sel;
  logic signed [OUT_EXT-1:0]  x_ext, y_ext;
  logic                       v_q, v_d;
  logic [FIELD_BITS-1:0]      x_q, y_q;
  logic [COLOUR_BITS-1:0]     colour_q;

  assign canvas_on = (cfg_i.canvas_width != '0) || (cfg_i.canvas_height != '0);
  assign wrap_on   = canvas_on && (cfg_i.edge_mode == EDGE_WRAP);

  // A negative value with a non-zero remainder lands at dimension minus it.
  assign x_fix = (x_neg_i && (x_rem_i != '0)) ? (cfg_i.canvas_width - x_rem_i) : x_rem_i;
  assign y_fix = (y_neg_i && (y_rem_i != '0)) ? (cfg_i.canvas_height - y_rem_i) : y_rem_i;

  assign x_orig = x_neg_i ? (~x_mag_i + 1'b1) : x_mag_i;
  assign y_orig = y_neg_i ? (~y_mag_i + 1'b1) : y_mag_i;

  assign x_sel = (wrap_on && (cfg_i.canvas_width != '0))  ? COORD_BITS'(x_fix) : x_orig;
  assign y_sel = (wrap_on && (cfg_i.canvas_height != '0)) ? COORD_BITS'(y_fix) : y_orig;

  assign x_ext = OUT_EXT'(signed'(x_sel));
  assign y_ext = OUT_EXT'(signed'(y_sel));

  assign ready_o = !v_q || ready_i;
  assign v_d     = ready_o ? valid_i : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q      <= x_ext[FIELD_BITS-1:0];
      y_q      <= y_ext[FIELD_BITS-1:0];
      colour_q <= colour_i;
    end
  end

  assign valid_o         = v_q;
  assign mapped_x_o      = x_q;
  assign mapped_y_o      = y_q;
  assign mapped_colour_o = colour_q;

endmodule

@@ hw/rtl/pixel_offset_clip_wrap_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_offset_clip_wrap_unit
// Pipeline: an input stage, the remainder cells and an output stage.
// Throughput: one pixel per cycle while the output is not stalled; one remainder cell per magnitude bit.
// Clipped pixels leave the input stage and produce no output transfer.
// Reset clears all configuration registers to zero and empties every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_offset_clip_wrap_unit #(
  parameter int COORD_BITS = poc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [poc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [poc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pixel_x [15:0], pixel_y [31:16], pixel_colour [55:32]
  input  logic [poc_pkg::TDATA_BITS-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mapped_x [15:0], mapped_y [31:16], mapped_colour [55:32]
  output logic [poc_pkg::TDATA_BITS-1:0]     m_axis_tdata
);
  import poc_pkg::*;

  localparam int NCELL = COORD_BITS;

  cfg_t cfg_q, cfg_d;

  logic [NCELL:0]          cv, cr, cxn, cyn;
  logic [COORD_BITS-1:0]   cxm [NCELL+1];
  logic [COORD_BITS-1:0]   cym [NCELL+1];
  logic [DIM_BITS-1:0]     cxr [NCELL+1];
  logic [DIM_BITS-1:0]     cyr [NCELL+1];
  logic [COLOUR_BITS-1:0]  ccol [NCELL+1];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_X:      cfg_d.offset_x      = signed'(cfg_data_i);
        CFG_OFFSET_Y:      cfg_d.offset_y      = signed'(cfg_data_i);
        CFG_CANVAS_WIDTH:  cfg_d.canvas_width  = cfg_data_i[DIM_BITS-1:0];
        CFG_CANVAS_HEIGHT: cfg_d.canvas_height = cfg_data_i[DIM_BITS-1:0];
        CFG_EDGE_MODE:     cfg_d.edge_mode     = edge_mode_e'(cfg_data_i[0]);
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  poc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .pixel_x_i      (s_axis_tdata[FIELD_BITS-1:0]),
    .pixel_y_i      (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .pixel_colour_i (s_axis_tdata[TDATA_BITS-1:2*FIELD_BITS]),
    .valid_o        (cv[0]),
    .ready_i        (cr[0]),
    .x_neg_o        (cxn[0]),
    .x_mag_o        (cxm[0]),
    .y_neg_o        (cyn[0]),
    .y_mag_o        (cym[0]),
    .colour_o       (ccol[0])
  );

  // The remainder starts at zero ahead of the first cell.
  assign cxr[0] = '0;
  assign cyr[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    poc_cell #(
      .COORD_BITS(COORD_BITS),
      .BIT       (NCELL - 1 - k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .width_i  (cfg_q.canvas_width),
      .height_i (cfg_q.canvas_height),
      .valid_i  (cv[k]),
      .ready_o  (cr[k]),
      .x_neg_i  (cxn[k]),
      .x_mag_i  (cxm[k]),
      .x_rem_i  (cxr[k]),
      .y_neg_i  (cyn[k]),
      .y_mag_i  (cym[k]),
      .y_rem_i  (cyr[k]),
      .colour_i (ccol[k]),
      .valid_o  (cv[k+1]),
      .ready_i  (cr[k+1]),
      .x_neg_o  (cxn[k+1]),
      .x_mag_o  (cxm[k+1]),
      .x_rem_o  (cxr[k+1]),
      .y_neg_o  (cyn[k+1]),
      .y_mag_o  (cym[k+1]),
      .y_rem_o  (cyr[k+1]),
      .colour_o (ccol[k+1])
    );
  end

  poc_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .valid_i         (cv[NCELL]),
    .ready_o         (cr[NCELL]),
    .x_neg_i         (cxn[NCELL]),
    .x_mag_i         (cxm[NCELL]),
    .x_rem_i         (cxr[NCELL]),
    .y_neg_i         (cyn[NCELL]),
    .y_mag_i         (cym[NCELL]),
    .y_rem_i         (cyr[NCELL]),
    .colour_i        (ccol[NCELL]),
    .valid_o         (m_axis_tvalid),
    .ready_i         (m_axis_tready),
    .mapped_x_o      (m_axis_tdata[FIELD_BITS-1:0]),
    .mapped_y_o      (m_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .mapped_colour_o (m_axis_tdata[TDATA_BITS-1:2*FIELD_BITS])
  );

`ifndef ASSERT_OFF
  // The input side only stalls when every stage holds a pixel and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> ((&cv) && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has a free stage");

  // A cell whose successor is not ready keeps its pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(cv[NCELL:1]) & ~$past(cr[NCELL:1]) & ~cv[NCELL:1]) == '0))
    else $error("a stalled cell lost its pixel");

  // A new output only appears after the last cell offered one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(cv[NCELL]))
    else $error("output became valid without a pixel from the last cell");
`endif

endmodule

@@ dv/tb_pixel_offset_clip_wrap_unit.sv @@
// ----------------------------------------------------------------------------
// tb_pixel_offset_clip_wrap_unit
// Self-checking bench for the pixel offset, clip and wrap unit. A short table
// of directed pixels covers the field extremes, both edge modes, the case
// with no canvas and the cases with one zero dimension. Random phases follow,
// each under a fresh configuration. Most pixels are mapped by a local predictor,
// the other table rows give a typed result or expect a drop, and each output
// transfer is checked field by field against the oldest expected pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pixel_offset_clip_wrap_unit;
  import poc_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 90;
  localparam int RAND_PHASES   = 11;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] colour;
    logic [FIELD_BITS-1:0]  y;
    logic [FIELD_BITS-1:0]  x;
  } pix_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_DROPPED
  } row_kind_e;

  typedef struct {
    int        set_idx;
    pix_t      pixel;
    row_kind_e kind;
    pix_t      mapped;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TDATA_BITS-1:0]    s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0]    m_axis_tdata;

  cfg_t     cur_cfg = '0;
  cfg_t     cfg_sets[$];
  dir_row_t dir_rows[$];
  pix_t     exp_pixels[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       quiet = 1'b0;
  bit       hold_req = 1'b0;

  pixel_offset_clip_wrap_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_offset_clip_wrap_unit test failed");
      $finish;
    end
  end

  // Maps one pixel under the current configuration; returns 0 when clipped.
  function automatic logic map_pixel(input pix_t pin, output pix_t pout);
    logic signed [FIELD_BITS-1:0] moved_x;
    logic signed [FIELD_BITS-1:0] moved_y;
    int cx, cy, off_x, off_y, dim_w, dim_h;
    moved_x = $signed(pin.x) + cur_cfg.offset_x;
    moved_y = $signed(pin.y) + cur_cfg.offset_y;
    cx      = int'(moved_x);
    cy      = int'(moved_y);
    off_x   = int'(cur_cfg.offset_x);
    off_y   = int'(cur_cfg.offset_y);
    dim_w   = int'(cur_cfg.canvas_width);
    dim_h   = int'(cur_cfg.canvas_height);
    pout    = pin;
    if (dim_w != 0 || dim_h != 0) begin
      if (cur_cfg.edge_mode == EDGE_CLIP) begin
        // The clip bound is tested at full precision, so the offset is undone
        // without any 16-bit wrap.
        if (cx < 0 || cx - off_x >= dim_w || cy < 0 || cy - off_y >= dim_h) begin
          return 1'b0;
        end
      end else begin
        if (dim_w != 0) begin
          cx = cx % dim_w;
          if (cx < 0) cx += dim_w;
        end
        if (dim_h != 0) begin
          cy = cy % dim_h;
          if (cy < 0) cy += dim_h;
        end
      end
    end
    pout.x = cx[FIELD_BITS-1:0];
    pout.y = cy[FIELD_BITS-1:0];
    return 1'b1;
  endfunction

  // Coordinate that lands near the canvas, either side of the offset.
  function automatic logic [FIELD_BITS-1:0] near_coord(
    input logic signed [FIELD_BITS-1:0] off,
    input logic [DIM_BITS-1:0]          dim
  );
    int base;
    base = ($urandom_range(0, 1) != 0) ? -int'(off) : 0;
    return FIELD_BITS'(base + int'($urandom_range(0, int'(dim) + 16)) - 8);
  endfunction

  function automatic logic [FIELD_BITS-1:0] extreme_offset();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [DIM_BITS-1:0] extreme_dim();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 15'd1;
      default: return 15'h7FFF;
    endcase
  endfunction

  function automatic cfg_t random_cfg(input int kind);
    cfg_t c;
    c.offset_x      = FIELD_BITS'($urandom);
    c.offset_y      = FIELD_BITS'($urandom);
    c.canvas_width  = DIM_BITS'($urandom);
    c.canvas_height = DIM_BITS'($urandom);
    c.edge_mode     = edge_mode_e'($urandom_range(0, 1));
    case (kind)
      0: begin
        c.canvas_width  = '0;
        c.canvas_height = '0;
      end
      1: begin
        c.offset_x      = FIELD_BITS'(int'($urandom_range(0, 400)) - 200);
        c.offset_y      = FIELD_BITS'(int'($urandom_range(0, 400)) - 200);
        c.canvas_width  = DIM_BITS'($urandom_range(1, 64));
        c.canvas_height = DIM_BITS'($urandom_range(1, 64));
        c.edge_mode     = EDGE_CLIP;
      end
      2: begin
        c.canvas_width  = DIM_BITS'($urandom_range(0, 64));
        c.canvas_height = DIM_BITS'($urandom_range(1, 64));
        c.edge_mode     = EDGE_WRAP;
      end
      3: begin
        c.canvas_width  = DIM_BITS'($urandom_range(1, 32767));
        c.canvas_height = DIM_BITS'($urandom_range(1, 32767));
        c.edge_mode     = EDGE_WRAP;
      end
      4: begin
        c.offset_x      = FIELD_BITS'(int'($urandom_range(0, 40)) - 20);
        c.offset_y      = FIELD_BITS'(int'($urandom_range(0, 40)) - 20);
        c.canvas_width  = ($urandom_range(0, 1) != 0) ? 15'd0 : 15'($urandom_range(1, 64));
        c.canvas_height = (c.canvas_width == 0) ? 15'($urandom_range(1, 64)) : 15'd0;
        c.edge_mode     = EDGE_CLIP;
      end
      default: begin
        c.offset_x      = extreme_offset();
        c.offset_y      = extreme_offset();
        c.canvas_width  = extreme_dim();
        c.canvas_height = extreme_dim();
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
             want);
    mismatch_count++;
  endtask

  task automatic add_row(input int set_idx, input logic [15:0] px, input logic [15:0] py,
                         input logic [23:0] colour, input row_kind_e kind,
                         input logic [15:0] ex, input logic [15:0] ey);
    dir_row_t r;
    r.set_idx = set_idx;
    r.pixel   = '{colour: colour, y: py, x: px};
    r.kind    = kind;
    r.mapped  = '{colour: colour, y: ey, x: ex};
    dir_rows.push_back(r);
  endtask

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_pixel(input pix_t p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic send_predicted(input pix_t p);
    pix_t q;
    send_pixel(p);
    if (map_pixel(p, q)) exp_pixels.push_back(q);
  endtask

  // Clipped pixels give no output, so the pipeline is given time to empty.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (exp_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_OFFSET_X;
    cfg_data_i  <= c.offset_x;
    @(posedge clk_i);
    cfg_index_i <= CFG_OFFSET_Y;
    cfg_data_i  <= c.offset_y;
    @(posedge clk_i);
    cfg_index_i <= CFG_CANVAS_WIDTH;
    cfg_data_i  <= CFG_DATA_BITS'(c.canvas_width);
    @(posedge clk_i);
    cfg_index_i <= CFG_CANVAS_HEIGHT;
    cfg_data_i  <= CFG_DATA_BITS'(c.canvas_height);
    @(posedge clk_i);
    cfg_index_i <= CFG_EDGE_MODE;
    cfg_data_i  <= CFG_DATA_BITS'(c.edge_mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_cfg = c;
  endtask

  // Output side: random back-pressure plus one long hold-off on request.
  initial begin : sink_ctrl
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Sampled mid-cycle, so the transfer completes at the following rising edge.
  always @(negedge clk_i) begin
    pix_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (exp_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(got.x), 32'hFFFF_FFFF);
      end else begin
        want = exp_pixels.pop_front();
        if (got.x !== want.x) report_mismatch("mapped_x", 32'(got.x), 32'(want.x));
        if (got.y !== want.y) report_mismatch("mapped_y", 32'(got.y), 32'(want.y));
        if (got.colour !== want.colour) begin
          report_mismatch("mapped_colour", 32'(got.colour), 32'(want.colour));
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    pix_t     p;
    int       cur_set;

    // Set 0 holds the reset values and is never written.
    cfg_sets.push_back('{16'sd0, 16'sd0, 15'd0, 15'd0, EDGE_CLIP});
    cfg_sets.push_back('{16'sd100, -16'sd5, 15'd64, 15'd32, EDGE_CLIP});
    cfg_sets.push_back('{-16'sd10, 16'sd5, 15'd7, 15'd0, EDGE_WRAP});
    cfg_sets.push_back('{16'sd5, 16'sd0, 15'd0, 15'd10, EDGE_CLIP});
    cfg_sets.push_back('{16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h7FFF, EDGE_WRAP});
    cfg_sets.push_back('{16'sh8000, 16'sh7FFF, 15'h7FFF, 15'd1, EDGE_CLIP});
    cfg_sets.push_back('{-16'sd1, 16'sd1, 15'd0, 15'd0, EDGE_WRAP});

    // No canvas after reset: pixels come out untouched.
    add_row(0, 16'h0000, 16'h0000, 24'h000000, ROW_TYPED, 16'h0000, 16'h0000);
    add_row(0, 16'h8000, 16'h7FFF, 24'hFFFFFF, ROW_TYPED, 16'h8000, 16'h7FFF);
    add_row(0, 16'h7FFF, 16'h8000, 24'h000001, ROW_TYPED, 16'h7FFF, 16'h8000);
    add_row(0, 16'hFFFF, 16'h0001, 24'h800000, ROW_TYPED, 16'hFFFF, 16'h0001);
    // No canvas in wrap mode: only the offset addition wraps.
    add_row(6, 16'h8000, 16'h7FFF, 24'hA5A5A5, ROW_TYPED, 16'h7FFF, 16'h8000);
    // Clip against a small canvas, around both bounds of each axis.
    add_row(1, -16'sd100, 16'sd5, 24'h123456, ROW_PREDICT, 16'h0, 16'h0);
    add_row(1, -16'sd101, 16'sd5, 24'h123456, ROW_DROPPED, 16'h0, 16'h0);
    add_row(1, 16'sd63, 16'sd31, 24'h654321, ROW_PREDICT, 16'h0, 16'h0);
    add_row(1, 16'sd64, 16'sd31, 24'h654321, ROW_PREDICT, 16'h0, 16'h0);
    add_row(1, 16'sd10, 16'sd4, 24'h0F0F0F, ROW_DROPPED, 16'h0, 16'h0);
    // Wrap with a zero height: y is left alone, x is reduced.
    add_row(2, 16'sd3, 16'sd100, 24'h00FF00, ROW_TYPED, 16'd0, 16'd105);
    add_row(2, 16'h0000, 16'h7FFF, 24'h0000FF, ROW_PREDICT, 16'h0, 16'h0);
    add_row(2, 16'h8000, 16'h0000, 24'hFF0000, ROW_PREDICT, 16'h0, 16'h0);
    // Clip with a zero width: only a moved x at or above zero and below the offset survives.
    add_row(3, -16'sd3, 16'sd2, 24'h111111, ROW_PREDICT, 16'h0, 16'h0);
    add_row(3, 16'sd0, 16'sd2, 24'h222222, ROW_PREDICT, 16'h0, 16'h0);
    add_row(3, -16'sd6, 16'sd2, 24'h333333, ROW_DROPPED, 16'h0, 16'h0);
    // Extreme offsets and dimensions.
    add_row(4, 16'h7FFF, 16'h8000, 24'h5A5A5A, ROW_PREDICT, 16'h0, 16'h0);
    add_row(4, 16'h0001, 16'hFFFF, 24'hC3C3C3, ROW_PREDICT, 16'h0, 16'h0);
    add_row(5, 16'h7FFF, 16'h8001, 24'h3C3C3C, ROW_PREDICT, 16'h0, 16'h0);
    add_row(5, 16'h8000, 16'h0000, 24'h7E7E7E, ROW_PREDICT, 16'h0, 16'h0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_set = 0;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.set_idx != cur_set) begin
        drain_block();
        apply_cfg(cfg_sets[row.set_idx]);
        cur_set = row.set_idx;
      end
      case (row.kind)
        ROW_TYPED: begin
          send_pixel(row.pixel);
          exp_pixels.push_back(row.mapped);
        end
        ROW_DROPPED: send_pixel(row.pixel);
        default:     send_predicted(row.pixel);
      endcase
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_block();
      apply_cfg(random_cfg((ph == 0) ? 0 : $urandom_range(0, 5)));
      // The first phase passes every pixel, so a long hold-off fills the block.
      if (ph == 0) hold_req = 1'b1;
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          p.x = FIELD_BITS'($urandom);
          p.y = FIELD_BITS'($urandom);
        end else begin
          p.x = near_coord(cur_cfg.offset_x, cur_cfg.canvas_width);
          p.y = near_coord(cur_cfg.offset_y, cur_cfg.canvas_height);
        end
        p.colour = COLOUR_BITS'($urandom);
        send_predicted(p);
      end
    end

    drain_block();
    if (mismatch_count == 0 && exp_pixels.size() == 0) begin
      $display("pixel_offset_clip_wrap_unit test passed");
    end else begin
      $display("pixel_offset_clip_wrap_unit test failed");
    end
    $finish;
  end

endmodule
